### hdl/tcw_pkg.sv
// Package for the text console writer: beat types, command codes, FSM states
// and fixed constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int CELL_W = 16;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] BLANK_CODE   = 8'h20;

  localparam logic [3:0] FG_RESET = 4'd7;
  localparam logic [3:0] BG_RESET = 4'd0;

  // Register select is byte address bit 2.
  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } tcw_cmd_t;

  typedef struct packed {
    tcw_cmd_t    cmd;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [10:0]       cursor;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } tcw_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_CLEAR,
    ST_RESULT
  } tcw_state_t;

endpackage

`default_nettype wire

### hdl/text_console_writer.sv
// Top level of the text console writer: configuration registers, output
// register and the sequencer/memory pair. Depends on tcw_pkg, tcw_ctrl and
// tcw_screen_ram.
//
//   Channel  Signals                                    Beat
//   req      req_valid / req_ready / req               tcw_in_t command
//   rsp      rsp_valid / rsp_ready / rsp               tcw_out_t result
//   apb      psel penable pwrite paddr pwdata prdata   32-bit register access
//
// A put that does not scroll, a no-op command and an out-of-range read go
// from ST_EXEC straight to ST_RESULT; an in-range read passes ST_READ for
// the registered memory read. A scroll walks the screen memory through its
// one read port and one write port: a copy sweep moves each row one row up,
// then a fill sweep blanks the last row. Clear blanks every cell in a sweep.
// Reset is synchronous and clears the cursor and control state; screen
// contents are unknown until written, so there is no clearing pass.
// A new command beat is taken while a finished result still waits on rsp;
// the sequencer only stalls when a second result is ready before then.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire tcw_in_t     req,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output tcw_out_t         rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic [3:0] fg_color;
  logic [3:0] bg_color;

  logic              start;
  logic              idle;
  logic              res_valid;
  logic              res_ready;
  tcw_out_t          res;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // Configuration registers. The write lands on the access cycle; byte
  // address bit 2 selects the register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= FG_RESET;
      bg_color <= BG_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_BG) begin
        bg_color <= pwdata[3:0];
      end else begin
        fg_color <= pwdata[3:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_BG) begin
      prdata = {28'd0, bg_color};
    end else begin
      prdata = {28'd0, fg_color};
    end
  end

  // Command side: the sequencer takes a beat whenever it is idle.
  assign req_ready = idle;
  assign start     = req_valid && req_ready;

  // Result side: a single output register decouples the sequencer from rsp.
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .attr      ({bg_color, fg_color}),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  tcw_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

### hdl/tcw_screen_ram.sv
// Screen memory: one write port and one read port, read data registered.
// Depends on tcw_pkg for the cell width.
`timescale 1ns / 1ps
`default_nettype none

module tcw_screen_ram
  import tcw_pkg::*;
#(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [CELL_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/tcw_ctrl.sv
// Command sequencer: cursor tracking, scroll copy, blank fill and clear sweeps
// over the screen memory. Depends on tcw_pkg and drives tcw_screen_ram ports.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire tcw_in_t           req,
  input  wire logic [7:0]        attr,
  output logic                   idle,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output tcw_out_t               res,
  output logic                   ram_we,
  output logic [$clog2(COLUMNS*ROWS)-1:0] ram_waddr,
  output logic [CELL_W-1:0]      ram_wdata,
  output logic                   ram_re,
  output logic [$clog2(COLUMNS*ROWS)-1:0] ram_raddr,
  input  wire logic [CELL_W-1:0] ram_rdata
);

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int AW         = $clog2(CELLS);
  localparam int PW         = $clog2(CELLS + 1);
  localparam int COLW       = $clog2(COLUMNS);
  localparam int SCROLL_CNT = COLUMNS * (ROWS - 1);

  localparam logic [AW-1:0]   COLS_A    = AW'(COLUMNS);
  localparam logic [AW-1:0]   LAST_BASE = AW'(SCROLL_CNT);
  localparam logic [AW-1:0]   LAST_CELL = AW'(CELLS - 1);
  localparam logic [PW-1:0]   COLS_P    = PW'(COLUMNS);
  localparam logic [PW-1:0]   SCROLL_END = PW'(SCROLL_CNT);
  localparam logic [PW-1:0]   SWEEP_END = PW'(CELLS - 1);
  localparam logic [COLW-1:0] LAST_COL  = COLW'(COLUMNS - 1);

  tcw_state_t        state, state_next;
  tcw_in_t           req_q, req_q_next;
  logic [AW-1:0]     cursor, cursor_next;
  logic [AW-1:0]     row_base, row_base_next;
  logic [COLW-1:0]   col, col_next;
  logic [PW-1:0]     ptr, ptr_next;
  logic [CELL_W-1:0] value_q, value_next;
  logic              scrolled_q, scrolled_next;

  logic [PW-1:0]     scroll_src;
  logic [PW-1:0]     ptr_prev;
  logic [31:0]       idx_ext;
  logic [31:0]       cursor_ext;
  logic [CELL_W-1:0] blank;

  assign scroll_src = ptr + COLS_P;
  assign ptr_prev   = ptr - PW'(1);
  assign idx_ext    = 32'(req_q.cell_index);
  assign cursor_ext = 32'(cursor);
  assign blank      = {attr, BLANK_CODE};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cursor   <= '0;
      row_base <= '0;
      col      <= '0;
      ptr      <= '0;
    end else begin
      state    <= state_next;
      cursor   <= cursor_next;
      row_base <= row_base_next;
      col      <= col_next;
      ptr      <= ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    req_q      <= req_q_next;
    value_q    <= value_next;
    scrolled_q <= scrolled_next;
  end

  always_comb begin
    state_next    = state;
    req_q_next    = req_q;
    cursor_next   = cursor;
    row_base_next = row_base;
    col_next      = col;
    ptr_next      = ptr;
    value_next    = value_q;
    scrolled_next = scrolled_q;
    ram_we        = 1'b0;
    ram_waddr     = ptr[AW-1:0];
    ram_wdata     = blank;
    ram_re        = 1'b0;
    ram_raddr     = scroll_src[AW-1:0];
    idle          = 1'b0;
    res_valid     = 1'b0;

    unique case (state)
      ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          req_q_next    = req;
          value_next    = '0;
          scrolled_next = 1'b0;
          state_next    = ST_EXEC;
        end
      end

      ST_EXEC: begin
        unique case (req_q.cmd)
          CMD_PUT: begin
            if (req_q.char_code == NEWLINE_CODE) begin
              if (row_base == LAST_BASE) begin
                ptr_next   = '0;
                state_next = ST_SCROLL;
              end else begin
                row_base_next = row_base + COLS_A;
                cursor_next   = row_base + COLS_A;
                col_next      = '0;
                state_next    = ST_RESULT;
              end
            end else begin
              ram_we    = 1'b1;
              ram_waddr = cursor;
              ram_wdata = {attr, req_q.char_code};
              if (cursor == LAST_CELL) begin
                ptr_next   = '0;
                state_next = ST_SCROLL;
              end else begin
                cursor_next = cursor + AW'(1);
                if (col == LAST_COL) begin
                  col_next      = '0;
                  row_base_next = row_base + COLS_A;
                end else begin
                  col_next = col + COLW'(1);
                end
                state_next = ST_RESULT;
              end
            end
          end
          CMD_CLEAR: begin
            ptr_next   = '0;
            state_next = ST_CLEAR;
          end
          CMD_READ: begin
            if (idx_ext < 32'(CELLS)) begin
              ram_re     = 1'b1;
              ram_raddr  = idx_ext[AW-1:0];
              state_next = ST_READ;
            end else begin
              state_next = ST_RESULT;
            end
          end
          CMD_NOP: begin
            state_next = ST_RESULT;
          end
        endcase
      end

      ST_READ: begin
        value_next = ram_rdata;
        state_next = ST_RESULT;
      end

      // Each cycle reads the cell one row below ptr and writes the cell read
      // in the previous cycle one row up.
      ST_SCROLL: begin
        if (ptr != SCROLL_END) begin
          ram_re = 1'b1;
        end
        if (ptr != '0) begin
          ram_we    = 1'b1;
          ram_waddr = ptr_prev[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (ptr == SCROLL_END) begin
          state_next = ST_FILL;
        end else begin
          ptr_next = ptr + PW'(1);
        end
      end

      ST_FILL: begin
        ram_we = 1'b1;
        if (ptr == SWEEP_END) begin
          cursor_next   = LAST_BASE;
          row_base_next = LAST_BASE;
          col_next      = '0;
          scrolled_next = 1'b1;
          state_next    = ST_RESULT;
        end else begin
          ptr_next = ptr + PW'(1);
        end
      end

      ST_CLEAR: begin
        ram_we = 1'b1;
        if (ptr == SWEEP_END) begin
          cursor_next   = '0;
          row_base_next = '0;
          col_next      = '0;
          state_next    = ST_RESULT;
        end else begin
          ptr_next = ptr + PW'(1);
        end
      end

      ST_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign res.cursor     = cursor_ext[10:0];
  assign res.cell_value = value_q;
  assign res.scrolled   = scrolled_q;

endmodule

`default_nettype wire

### hdl/tcw_checker.sv
// Port-level checker for the text console writer, bound to the top level.
// Depends on tcw_pkg for the beat types.
`timescale 1ns / 1ps
`default_nettype none

module tcw_checker
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     req_valid,
  input wire logic     req_ready,
  input wire logic     rsp_valid,
  input wire logic     rsp_ready,
  input wire tcw_out_t rsp
);

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int LAST_BASE = COLUMNS * (ROWS - 1);
  localparam bit FITS      = (CELLS <= 2048);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  // The block handles one command at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("command accepted on consecutive cycles");

  // The reported cursor always lies on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && FITS |-> 32'(rsp.cursor) < CELLS)
    else $error("cursor beyond the screen");

  // A scroll lands the cursor at the start of the last row and reads nothing.
  a_scroll_home: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.scrolled && FITS |->
      32'(rsp.cursor) == LAST_BASE && rsp.cell_value == '0)
    else $error("scroll result inconsistent");

  // A stalled result holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire
